@@ rtl/gld_pkg.sv @@
// Shared types and constants for the GIF LZW pixel decoder.
package gld_pkg;

  localparam int TableEntriesDef = 4096;
  localparam int AddrBitsDef     = 20;
  localparam logic [3:0]  MaxWidth     = 4'd12;
  localparam logic [11:0] LenMax       = 12'hFFF;
  localparam logic [3:0]  MinCodeReset = 4'd8;
  localparam logic [3:0]  MinCodeLow   = 4'd2;
  localparam logic [3:0]  MinCodeHigh  = 4'd8;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BEYOND   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_AFTER    = 3'd3,
    STAT_ADDR_OVF = 3'd4
  } status_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [11:0] prefix;
    logic [7:0]  suffix;
    logic [11:0] length;
    logic [7:0]  first;
  } entry_t;

endpackage

@@ rtl/gld_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gld_ram import gld_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gld_front.sv @@
// Input queue that accepts request beats and hands them to the decode engine.
module gld_front import gld_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  output logic  head_valid_o,
  output item_t head_o,
  input  logic  pop_i
);

  item_t      slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i & ~in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i & head_valid_o;
  assign head_o       = slot_q[rptr_q];

  // Storage for queued beats.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= in_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/gld_back.sv @@
// Decode engine: bit holder, code table, string walk and result register.
module gld_back import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int ADDR_BITS     = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic [3:0]           mcs_i,
  input  logic                 head_valid_i,
  input  item_t                head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 pixel_valid_o,
  output logic [7:0]           pixel_value_o,
  output logic [ADDR_BITS-1:0] pixel_address_o,
  output logic                 need_byte_o,
  output logic                 done_res_o,
  output logic [2:0]           status_o
);

  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int SumW = (ADDR_BITS + 2 > 13) ? ADDR_BITS + 2 : 13;

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_WAIT = 2'b10
  } state_e;

  state_e           st_q, st_d;
  item_t            held_q;
  logic [23:0]      bh_q, bh_d;
  logic [4:0]       bc_q, bc_d;
  logic [3:0]       cw_q, cw_d;
  logic [12:0]      nfc_q, nfc_d;
  logic [11:0]      prev_q, prev_d;
  logic [11:0]      plen_q, plen_d;
  logic [7:0]       pfirst_q, pfirst_d;
  logic             await_q, await_d;
  logic             exp_q, exp_d;
  logic [11:0]      cur_q, cur_d;
  logic [ADDR_BITS:0] wp_q, wp_d;
  logic [11:0]      span_q, span_d;
  logic             end_q, end_d;

  logic                 ov_q;
  logic                 opv_q;
  logic [7:0]           oval_q;
  logic [ADDR_BITS-1:0] oaddr_q;
  logic                 oneed_q;
  logic                 odone_q;
  status_e              ostat_q;

  item_t                item;
  logic                 active, can_load, need_read, commit;
  logic [8:0]           cc;
  logic [11:0]          cc12, code, lk;
  logic [23:0]          msk;
  logic                 root;
  entry_t               ent, went, nent, ram_rd;
  logic                 walk_en, wr_en;
  logic [11:0]          slen;
  logic [11:0]          off;
  logic [SumW-1:0]      asum, wsum, limit;
  logic                 pv;
  logic [7:0]           pval;
  logic [ADDR_BITS-1:0] paddr;
  status_e              stat;

  assign can_load = ~ov_q | ~out_stall_i;
  assign item     = (st_q == S_WAIT) ? held_q : head_i;
  assign active   = (st_q == S_WAIT) | (head_valid_i & can_load);
  assign pop_o    = (st_q == S_RUN) & head_valid_i & can_load;

  assign cc    = 9'd1 << mcs_i;
  assign cc12  = {3'b000, cc};
  assign msk   = (24'd1 << cw_q) - 24'd1;
  assign code  = 12'(bh_q & msk);
  assign lk    = exp_q ? cur_q : code;
  assign root  = (lk < cc12);
  assign limit = SumW'(1) << ADDR_BITS;
  assign slen  = (plen_q == LenMax) ? LenMax : plen_q + 12'd1;

  // Root codes are implied; stored entries come from the table.
  always_comb begin
    if (root) begin
      ent = '{prefix: 12'd0, suffix: lk[7:0], length: 12'd1, first: lk[7:0]};
    end else begin
      ent = ram_rd;
    end
  end

  // One decode step.
  always_comb begin
    bh_d = bh_q; bc_d = bc_q; cw_d = cw_q; nfc_d = nfc_q;
    prev_d = prev_q; plen_d = plen_q; pfirst_d = pfirst_q;
    await_d = await_q; exp_d = exp_q; cur_d = cur_q; wp_d = wp_q;
    span_d = span_q; end_d = end_q;
    walk_en = 1'b0; wr_en = 1'b0; need_read = 1'b0;
    went = ent; nent = ent;
    pv = 1'b0; pval = 8'd0; paddr = '0; stat = STAT_OK;
    off = 12'd0; asum = '0; wsum = '0;

    if (end_q) begin
      stat = STAT_AFTER;
    end else if (item.req_type == REQ_BYTE) begin
      if (bc_q > 5'd16) begin
        stat = STAT_FULL;
      end else begin
        bh_d = bh_q | (24'(item.data_byte) << bc_q);
        bc_d = bc_q + 5'd8;
      end
    end else if (exp_q) begin
      need_read = ~root;
      walk_en   = 1'b1;
    end else if (bc_q >= {1'b0, cw_q}) begin
      bh_d = bh_q >> cw_q;
      bc_d = bc_q - {1'b0, cw_q};
      if (code == cc12) begin
        cw_d    = mcs_i + 4'd1;
        nfc_d   = {4'd0, cc} + 13'd2;
        await_d = 1'b1;
      end else if (code == cc12 + 12'd1) begin
        end_d = 1'b1;
      end else if (await_q) begin
        if (code >= cc12) begin
          stat = STAT_BEYOND;
        end else begin
          await_d  = 1'b0;
          prev_d   = code;
          plen_d   = 12'd1;
          pfirst_d = code[7:0];
          cur_d    = code;
          span_d   = 12'd1;
          walk_en  = 1'b1;
        end
      end else if ({1'b0, code} < nfc_q) begin
        need_read = ~root;
        nent = '{prefix: prev_q, suffix: ent.first, length: slen, first: pfirst_q};
        wr_en    = (nfc_q < 13'(TABLE_ENTRIES));
        prev_d   = code;
        plen_d   = ent.length;
        pfirst_d = ent.first;
        cur_d    = code;
        span_d   = ent.length;
        walk_en  = 1'b1;
      end else if (({1'b0, code} == nfc_q) && (nfc_q < 13'(TABLE_ENTRIES))) begin
        nent = '{prefix: prev_q, suffix: pfirst_q, length: slen, first: pfirst_q};
        went     = nent;
        wr_en    = 1'b1;
        prev_d   = code;
        plen_d   = slen;
        cur_d    = code;
        span_d   = slen;
        walk_en  = 1'b1;
      end else begin
        stat = STAT_BEYOND;
      end
      // Table growth and width step.
      if (wr_en) begin
        nfc_d = nfc_q + 13'd1;
        if ((cw_q < MaxWidth) && (nfc_d == (13'd1 << cw_q))) begin
          cw_d = cw_q + 4'd1;
        end
      end
    end

    // Emit the pixel under the cursor, then follow the prefix chain.
    if (walk_en) begin
      off  = (went.length == 12'd0) ? 12'd0 : went.length - 12'd1;
      asum = SumW'(wp_q) + SumW'(off);
      if (asum >= limit) begin
        stat = STAT_ADDR_OVF;
      end else begin
        pv    = 1'b1;
        pval  = went.suffix;
        paddr = asum[ADDR_BITS-1:0];
      end
      if (went.length <= 12'd1) begin
        exp_d = 1'b0;
        wsum  = SumW'(wp_q) + SumW'(span_d);
        wp_d  = (wsum > limit) ? limit[ADDR_BITS:0] : wsum[ADDR_BITS:0];
      end else begin
        cur_d = went.prefix;
        exp_d = 1'b1;
      end
    end
  end

  assign commit = active & ~((st_q == S_RUN) & need_read);

  // Next engine state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_RUN: begin
        if (active & need_read) begin
          st_d = S_WAIT;
        end
      end
      S_WAIT: begin
        st_d = S_RUN;
      end
      default: begin
        st_d = S_RUN;
      end
    endcase
  end

  gld_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (commit & wr_en),
    .waddr_i(nfc_q[AW-1:0]),
    .wdata_i(nent),
    .re_i   ((st_q == S_RUN) & active & need_read),
    .raddr_i(lk[AW-1:0]),
    .rdata_o(ram_rd)
  );

  // Beat held across a table read.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      held_q <= head_i;
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_RUN;
      bh_q <= '0; bc_q <= '0;
      cw_q <= MinCodeReset + 4'd1;
      nfc_q <= 13'd258;
      prev_q <= '0; plen_q <= '0; pfirst_q <= '0;
      await_q <= 1'b1; exp_q <= 1'b0; cur_q <= '0;
      wp_q <= '0; span_q <= '0; end_q <= 1'b0;
    end else if (restart_i) begin
      st_q <= S_RUN;
      bh_q <= '0; bc_q <= '0;
      cw_q <= mcs_i + 4'd1;
      nfc_q <= {4'd0, cc} + 13'd2;
      prev_q <= '0; plen_q <= '0; pfirst_q <= '0;
      await_q <= 1'b1; exp_q <= 1'b0; cur_q <= '0;
      wp_q <= '0; span_q <= '0; end_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (commit) begin
        bh_q <= bh_d; bc_q <= bc_d; cw_q <= cw_d; nfc_q <= nfc_d;
        prev_q <= prev_d; plen_q <= plen_d; pfirst_q <= pfirst_d;
        await_q <= await_d; exp_q <= exp_d; cur_q <= cur_d;
        wp_q <= wp_d; span_q <= span_d; end_q <= end_d;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (restart_i) begin
      ov_q <= 1'b0;
    end else if (commit) begin
      ov_q <= 1'b1;
    end else if (~out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      opv_q   <= pv;
      oval_q  <= pval;
      oaddr_q <= paddr;
      oneed_q <= ~exp_d & ~end_d & (bc_d < {1'b0, cw_d});
      odone_q <= end_d;
      ostat_q <= stat;
    end
  end

  assign out_valid_o     = ov_q;
  assign pixel_valid_o   = opv_q;
  assign pixel_value_o   = oval_q;
  assign pixel_address_o = oaddr_q;
  assign need_byte_o     = oneed_q;
  assign done_res_o      = odone_q;
  assign status_o        = ostat_q;

endmodule

@@ rtl/gif_lzw_pixel_decoder.sv @@
// GIF LZW pixel decoder top level with configuration port.
// Byte beats, advance beats on root codes or root-code walk steps, and clear,
// end and error codes need no table read; an advance whose code or walk
// cursor names a stored table entry passes through the wait state for the
// registered read of the code table. One result beat comes out for every request beat,
// through a result register, and a two-beat input queue lets requests keep
// arriving while a result waits. Writing min_code_size restarts decoding.
module gif_lzw_pixel_decoder import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int ADDR_BITS     = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 pixel_valid_o,
  output logic [7:0]           pixel_value_o,
  output logic [ADDR_BITS-1:0] pixel_address_o,
  output logic                 need_byte_o,
  output logic                 done_res_o,
  output logic [2:0]           status_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [3:0] mcs_q;
  logic [3:0] wv;
  logic       cfg_wr;
  logic       head_valid, pop;
  item_t      head, in_item;

  // Register write with range clamp.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign wv     = pwdata[3:0];
  assign prdata = {28'd0, mcs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q <= MinCodeReset;
    end else if (cfg_wr) begin
      if (wv < MinCodeLow) begin
        mcs_q <= MinCodeLow;
      end else if (wv > MinCodeHigh) begin
        mcs_q <= MinCodeHigh;
      end else begin
        mcs_q <= wv;
      end
    end
  end

  assign in_item = '{req_type: req_type_i, data_byte: data_byte_i};

  gld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  gld_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (cfg_wr),
    .mcs_i          (cfg_wr ? ((wv < MinCodeLow) ? MinCodeLow :
                               ((wv > MinCodeHigh) ? MinCodeHigh : wv)) : mcs_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_valid_o  (pixel_valid_o),
    .pixel_value_o  (pixel_value_o),
    .pixel_address_o(pixel_address_o),
    .need_byte_o    (need_byte_o),
    .done_res_o     (done_res_o),
    .status_o       (status_o)
  );

endmodule
